// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the zero/literal run decoder RTL.
// Define ASSERT_OFF to compile every check out of the design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, held off while reset is asserted
`define ZLR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset
`define ZLR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ZLR_ASSERT(lbl, clk, rstn, prop, msg)
`define ZLR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/zlr_pkg.sv -----
// Shared types, constants and helpers for the zero/literal run decoder.
// No dependencies.
package zlr_pkg;

    // Field and internal widths
    localparam int DIM_W   = 13;
    localparam int TOTAL_W = 26;
    localparam int TOKEN_W = 32;
    localparam int ADDR_W  = 24;
    localparam int COUNT_W = 25;
    localparam int PIXEL_W = 16;

    // Largest dimension a 13-bit register can hold
    localparam int DIM_MAX = 8191;

    // Dimension reset value
    localparam int DIM_RST = 512;

    // Marker that opens a frame with a zero run
    localparam logic [PIXEL_W-1:0] MARKER_ZERO_FIRST = 16'hFFFF;

    // Register indexes (paddr bit 2)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Frame geometry handed from the register block to the decoder
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
    } t_frame_cfg;

    // Clamp a dimension into 1..maxv
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/zero_literal_run_decoder.sv -----
// Zero/literal run decoder top level: token input register, register block
// and decode stage. Depends on zlr_pkg, zlr_cfg and zlr_dec.
// Path: a token passes the input register, then the result register of the decode stage, to its write or fill request.
// Throughput: one token per cycle while the output is not stalled; the input register feeds the decode
// stage, which updates counters and compares combinationally.
// Reset (synchronous, active low): waits for a frame marker, frame 512x512.
module zero_literal_run_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_frame_start,
    input  logic [zlr_pkg::TOKEN_W-1:0] i_token_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [zlr_pkg::ADDR_W-1:0]  o_write_address,
    output logic [zlr_pkg::COUNT_W-1:0] o_fill_count,
    output logic [zlr_pkg::PIXEL_W-1:0] o_pixel_value,
    output logic                        o_frame_done
);

    zlr_pkg::t_frame_cfg          frame_cfg;
    logic                         r_s1_valid, n_s1_valid;
    logic                         r_s1_start;
    logic [zlr_pkg::TOKEN_W-1:0]  r_s1_token;
    logic                         dec_adv;
    logic                         in_take;

    zlr_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (frame_cfg)
    );

    // Stall input only while the held token cannot move on
    assign o_in_stall = r_s1_valid && !dec_adv;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        if (in_take) begin
            n_s1_valid = 1'b1;
        end else if (dec_adv) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    // Hold the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_start <= i_frame_start;
            r_s1_token <= i_token_word;
        end
    end

    zlr_dec u_dec (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (frame_cfg),
        .i_valid         (r_s1_valid),
        .i_start         (r_s1_start),
        .i_token         (r_s1_token),
        .o_adv           (dec_adv),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_write_address (o_write_address),
        .o_fill_count    (o_fill_count),
        .o_pixel_value   (o_pixel_value),
        .o_frame_done    (o_frame_done)
    );

endmodule

// ----- hw/rtl/zlr_cfg.sv -----
// Configuration registers of the run decoder: frame width and height on an
// APB-style port, plus the registered pixel total. Depends on zlr_pkg.
module zlr_cfg #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output zlr_pkg::t_frame_cfg o_cfg
);

    localparam int MAXW_INT = (MAX_WIDTH > zlr_pkg::DIM_MAX) ? zlr_pkg::DIM_MAX : MAX_WIDTH;
    localparam int MAXH_INT = (MAX_HEIGHT > zlr_pkg::DIM_MAX) ? zlr_pkg::DIM_MAX : MAX_HEIGHT;
    localparam logic [zlr_pkg::DIM_W-1:0] MAXW = zlr_pkg::DIM_W'(MAXW_INT);
    localparam logic [zlr_pkg::DIM_W-1:0] MAXH = zlr_pkg::DIM_W'(MAXH_INT);
    localparam int RSTW_INT = (zlr_pkg::DIM_RST > MAXW_INT) ? MAXW_INT : zlr_pkg::DIM_RST;
    localparam int RSTH_INT = (zlr_pkg::DIM_RST > MAXH_INT) ? MAXH_INT : zlr_pkg::DIM_RST;
    localparam logic [zlr_pkg::TOTAL_W-1:0] TOTAL_RST = zlr_pkg::TOTAL_W'(RSTW_INT * RSTH_INT);

    logic [zlr_pkg::DIM_W-1:0]   r_width, n_width;
    logic [zlr_pkg::DIM_W-1:0]   r_height, n_height;
    logic [zlr_pkg::TOTAL_W-1:0] r_total, n_total;
    logic                        wr_en;
    logic                        sel_h;
    logic [zlr_pkg::DIM_W-1:0]   new_dim;
    logic [zlr_pkg::DIM_W-1:0]   mul_a, mul_b;

    assign wr_en   = psel && penable && pwrite;
    assign sel_h   = (paddr[2] == zlr_pkg::REG_HEIGHT);
    assign new_dim = pwdata[zlr_pkg::DIM_W-1:0];

    // Pick the new clamped dimension and the held one for the total
    always_comb begin
        if (sel_h) begin
            mul_a = zlr_pkg::clamp_dim(r_width, MAXW);
            mul_b = zlr_pkg::clamp_dim(new_dim, MAXH);
        end else begin
            mul_a = zlr_pkg::clamp_dim(new_dim, MAXW);
            mul_b = zlr_pkg::clamp_dim(r_height, MAXH);
        end
    end

    // Next register values on a write
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_total  = r_total;
        if (wr_en) begin
            if (sel_h) begin
                n_height = new_dim;
            end else begin
                n_width = new_dim;
            end
            n_total = zlr_pkg::TOTAL_W'(mul_a) * zlr_pkg::TOTAL_W'(mul_b);
        end
    end

    // Hold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= zlr_pkg::DIM_W'(zlr_pkg::DIM_RST);
            r_height <= zlr_pkg::DIM_W'(zlr_pkg::DIM_RST);
            r_total  <= TOTAL_RST;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_total  <= n_total;
        end
    end

    // Read back the addressed register
    assign prdata = sel_h ? {{(32-zlr_pkg::DIM_W){1'b0}}, r_height}
                          : {{(32-zlr_pkg::DIM_W){1'b0}}, r_width};
    assign pready = 1'b1;
    assign o_cfg.total = r_total;

endmodule

// ----- hw/rtl/zlr_dec.sv -----
// Decode state and result register of the run decoder: one token per cycle in unless
// a held request stalls, at most one write or fill request out. Depends on zlr_pkg.
`include "assert_macros.svh"
module zlr_dec (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  zlr_pkg::t_frame_cfg           i_cfg,
    input  logic                          i_valid,
    input  logic                          i_start,
    input  logic [zlr_pkg::TOKEN_W-1:0]   i_token,
    output logic                          o_adv,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [zlr_pkg::ADDR_W-1:0]    o_write_address,
    output logic [zlr_pkg::COUNT_W-1:0]   o_fill_count,
    output logic [zlr_pkg::PIXEL_W-1:0]   o_pixel_value,
    output logic                          o_frame_done
);

    logic                          r_expect_marker, n_expect_marker;
    logic                          r_in_literals, n_in_literals;
    logic                          r_zero_mode, n_zero_mode;
    logic [zlr_pkg::TOKEN_W-1:0]   r_literals_left, n_literals_left;
    logic [zlr_pkg::TOTAL_W-1:0]   r_pixel_index, n_pixel_index;
    logic                          r_frame_full, n_frame_full;

    logic                          r_out_valid, n_out_valid;
    logic [zlr_pkg::ADDR_W-1:0]    r_out_addr, n_out_addr;
    logic [zlr_pkg::COUNT_W-1:0]   r_out_count, n_out_count;
    logic [zlr_pkg::PIXEL_W-1:0]   r_out_value, n_out_value;
    logic                          r_out_done, n_out_done;

    logic [zlr_pkg::TOTAL_W-1:0]   remain;
    logic                          past_end;
    logic                          tok_short;
    logic                          produce;

    // Consume the held token whenever the result register can take a request
    assign o_adv = i_valid && (!r_out_valid || !i_out_stall);

    assign past_end  = (r_pixel_index >= i_cfg.total);
    assign remain    = i_cfg.total - r_pixel_index;
    assign tok_short = (i_token < {{(zlr_pkg::TOKEN_W-zlr_pkg::TOTAL_W){1'b0}}, remain});

    // Decode one token
    always_comb begin
        n_expect_marker = r_expect_marker;
        n_in_literals   = r_in_literals;
        n_zero_mode     = r_zero_mode;
        n_literals_left = r_literals_left;
        n_pixel_index   = r_pixel_index;
        n_frame_full    = r_frame_full;
        produce         = 1'b0;
        n_out_addr      = r_out_addr;
        n_out_count     = r_out_count;
        n_out_value     = r_out_value;
        n_out_done      = r_out_done;
        if (o_adv) begin
            if (i_start || r_expect_marker) begin
                // Marker: restart the frame
                n_expect_marker = 1'b0;
                n_in_literals   = 1'b0;
                n_literals_left = '0;
                n_pixel_index   = '0;
                n_frame_full    = 1'b0;
                n_zero_mode     = (i_token[zlr_pkg::PIXEL_W-1:0] == zlr_pkg::MARKER_ZERO_FIRST);
            end else if (r_frame_full) begin
                // Drop tokens after the frame is full
            end else if (past_end) begin
                n_frame_full = 1'b1;
            end else if (r_in_literals) begin
                // Single pixel write
                produce         = 1'b1;
                n_out_addr      = r_pixel_index[zlr_pkg::ADDR_W-1:0];
                n_out_count     = zlr_pkg::COUNT_W'(1);
                n_out_value     = i_token[zlr_pkg::PIXEL_W-1:0];
                n_out_done      = (remain == zlr_pkg::TOTAL_W'(1));
                n_frame_full    = n_out_done;
                n_pixel_index   = r_pixel_index + zlr_pkg::TOTAL_W'(1);
                n_literals_left = r_literals_left - zlr_pkg::TOKEN_W'(1);
                if (r_literals_left == zlr_pkg::TOKEN_W'(1)) begin
                    n_in_literals = 1'b0;
                    n_zero_mode   = 1'b1;
                end
            end else if (i_token == '0) begin
                // Empty run: toggle the mode
                n_zero_mode = !r_zero_mode;
            end else if (!r_zero_mode) begin
                // Literal run length
                n_in_literals   = 1'b1;
                n_literals_left = i_token;
            end else begin
                // Zero run, clipped to the frame end
                produce      = 1'b1;
                n_out_addr   = r_pixel_index[zlr_pkg::ADDR_W-1:0];
                n_out_value  = '0;
                n_zero_mode  = 1'b0;
                n_out_done   = !tok_short;
                n_frame_full = !tok_short;
                if (tok_short) begin
                    n_out_count   = i_token[zlr_pkg::COUNT_W-1:0];
                    n_pixel_index = r_pixel_index + i_token[zlr_pkg::TOTAL_W-1:0];
                end else begin
                    n_out_count   = remain[zlr_pkg::COUNT_W-1:0];
                    n_pixel_index = i_cfg.total;
                end
            end
        end
    end

    // Load a new request, or drop the held one once taken
    always_comb begin
        if (produce) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Hold decode state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_marker <= 1'b1;
            r_in_literals   <= 1'b0;
            r_zero_mode     <= 1'b0;
            r_literals_left <= '0;
            r_pixel_index   <= '0;
            r_frame_full    <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_expect_marker <= n_expect_marker;
            r_in_literals   <= n_in_literals;
            r_zero_mode     <= n_zero_mode;
            r_literals_left <= n_literals_left;
            r_pixel_index   <= n_pixel_index;
            r_frame_full    <= n_frame_full;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_out_addr  <= n_out_addr;
            r_out_count <= n_out_count;
            r_out_value <= n_out_value;
            r_out_done  <= n_out_done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_address = r_out_addr;
    assign o_fill_count    = r_out_count;
    assign o_pixel_value   = r_out_value;
    assign o_frame_done    = r_out_done;

    // A pending last-pixel request means the frame is marked full
    `ZLR_ASSERT(a_done_full, i_clk, i_rst_n, (r_out_valid && r_out_done) |-> r_frame_full, "frame_done request without full frame")
    // A literal run in progress always has literals left
    `ZLR_ASSERT(a_lit_left, i_clk, i_rst_n, r_in_literals |-> (r_literals_left != '0), "literal run with no literals left")
    // Only zero runs carry a fill count other than one, and they write zero
    `ZLR_ASSERT(a_fill_zero, i_clk, i_rst_n, (r_out_valid && (r_out_count != zlr_pkg::COUNT_W'(1))) |-> (r_out_value == '0), "multi-pixel fill with nonzero value")
    // Waiting for a marker excludes a literal run
    `ZLR_ASSERT(a_marker_idle, i_clk, i_rst_n, r_expect_marker |-> !r_in_literals, "literal run while expecting marker")

endmodule
